// File: rtl/bni_pkg.sv
// Shared constants, types and codes for the batch normalization block.
package bni_pkg;

	localparam int CHANNELS = 64;
	localparam int CH_W     = 6;
	localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DATA_W   = 16;
	localparam int TAB_W    = 32;

	localparam int SQRT_STEPS = 19;
	localparam int NUM_W      = 37;
	localparam int QUOT_W     = 26;
	localparam int ROOT_W     = 19;

	localparam logic [DATA_W-1:0] EPS_RESET = 16'd1;

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_PROCESS = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		PS_IDLE,
		PS_SQRT,
		PS_PREP,
		PS_DIV,
		PS_SIGN,
		PS_MUL,
		PS_WRITE
	} pstate_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [TAB_W-1:0]  scale;
		logic [TAB_W-1:0]  offset;
	} tab_wr_t;

endpackage

// File: rtl/bni_ram.sv
// Generic simple dual-port RAM with registered read.
module bni_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/bni_param.sv
// Load path: iterative square root and division, then offset computation.
module bni_param (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bni_pkg::CH_W-1:0]   channel,
	input  logic signed [15:0]         mean,
	input  logic [15:0]                variance,
	input  logic signed [15:0]         beta,
	input  logic signed [15:0]         gamma,
	input  logic [15:0]                epsilon,
	output logic                       busy,
	output bni_pkg::tab_wr_t           wr
);

	bni_pkg::pstate_t state_q, state_d;

	logic [5:0]                        cnt_q;
	logic [bni_pkg::ADDR_W-1:0]        addr_q;
	logic                              ok_q;
	logic signed [15:0]                mean_q;
	logic signed [15:0]                beta_q;
	logic                              neg_q;
	logic [15:0]                       mag_q;
	logic [37:0]                       x_q;
	logic [21:0]                       rem_q;
	logic [bni_pkg::ROOT_W-1:0]        root_q;
	logic [bni_pkg::NUM_W-1:0]         num_q;
	logic [19:0]                       drem_q;
	logic [bni_pkg::QUOT_W-1:0]        quot_q;
	logic signed [26:0]                scale_q;
	logic signed [42:0]                prod_q;

	logic [16:0]  vsum;
	logic [21:0]  rem_n, trial;
	logic         rbit;
	logic [20:0]  drem_n;
	logic         dbit;
	logic signed [42:0] rnd;
	logic signed [31:0] beta16;

	assign vsum   = 17'(variance) + 17'(epsilon);
	assign rem_n  = {rem_q[19:0], x_q[37:36]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign rbit   = (rem_n >= trial);
	assign drem_n = {drem_q, num_q[bni_pkg::NUM_W-1]};
	assign dbit   = (drem_n >= {2'b00, root_q});
	assign rnd    = (prod_q + 43'sd2048) >>> 12;
	assign beta16 = {{12{beta_q[15]}}, beta_q, 4'b0000};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bni_pkg::PS_IDLE:  if (start) state_d = bni_pkg::PS_SQRT;
			bni_pkg::PS_SQRT:  if (cnt_q == 6'd0) state_d = bni_pkg::PS_PREP;
			bni_pkg::PS_PREP:  state_d = (root_q == '0) ? bni_pkg::PS_SIGN : bni_pkg::PS_DIV;
			bni_pkg::PS_DIV:   if (cnt_q == 6'd0) state_d = bni_pkg::PS_SIGN;
			bni_pkg::PS_SIGN:  state_d = bni_pkg::PS_MUL;
			bni_pkg::PS_MUL:   state_d = bni_pkg::PS_WRITE;
			bni_pkg::PS_WRITE: state_d = bni_pkg::PS_IDLE;
			default:           state_d = bni_pkg::PS_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != bni_pkg::PS_IDLE);
		wr.we     = (state_q == bni_pkg::PS_WRITE) && ok_q;
		wr.addr   = addr_q;
		wr.scale  = 32'(scale_q);
		wr.offset = beta16 - 32'(rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bni_pkg::PS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bni_pkg::PS_IDLE: begin
				if (start) begin
					addr_q <= bni_pkg::ADDR_W'(channel);
					ok_q   <= (13'(channel) < 13'(bni_pkg::CHANNELS));
					mean_q <= mean;
					beta_q <= beta;
					neg_q  <= gamma[15];
					mag_q  <= gamma[15] ? 16'(-gamma) : 16'(gamma);
					x_q    <= {1'b0, vsum, 20'd0};
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= 6'(bni_pkg::SQRT_STEPS - 1);
				end
			end
			bni_pkg::PS_SQRT: begin
				x_q    <= {x_q[35:0], 2'b00};
				rem_q  <= rbit ? rem_n - trial : rem_n;
				root_q <= {root_q[bni_pkg::ROOT_W-2:0], rbit};
				cnt_q  <= cnt_q - 6'd1;
			end
			bni_pkg::PS_PREP: begin
				num_q  <= {1'b0, mag_q, 20'd0} + bni_pkg::NUM_W'(root_q >> 1);
				drem_q <= '0;
				quot_q <= '0;
				cnt_q  <= 6'(bni_pkg::NUM_W - 1);
			end
			bni_pkg::PS_DIV: begin
				num_q  <= {num_q[bni_pkg::NUM_W-2:0], 1'b0};
				drem_q <= dbit ? 20'(drem_n - {2'b00, root_q}) : drem_n[19:0];
				quot_q <= {quot_q[bni_pkg::QUOT_W-2:0], dbit};
				cnt_q  <= cnt_q - 6'd1;
			end
			bni_pkg::PS_SIGN: begin
				scale_q <= neg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
			end
			bni_pkg::PS_MUL: begin
				prod_q <= scale_q * mean_q;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/batch_norm_inference_top.sv
// Top level: channel tables, process pipeline and load sequencer.
//
// channel  | handshake          | payload
// input    | in_valid/in_stall  | command channel mean variance beta gamma sample
// output   | out_valid/out_stall| result saturated
// config   | cfg_we             | cfg_wdata (epsilon)
//
// Process requests: one per cycle unless out_stall holds the pipeline or a load is busy;
// each passes through table read, multiply, and add and clamp registers.
// Load requests: no new request is taken while the 19-step root and 37-step divider run
// (the divider is skipped when variance plus epsilon is zero).
// Reset clears control and sets epsilon to its reset value; tables are undefined until loaded.
// out_stall, while the output is valid, holds the whole process pipeline and stalls the input.
module batch_norm_inference_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     command,
	input  logic [bni_pkg::CH_W-1:0] channel,
	input  logic signed [15:0]       mean,
	input  logic [15:0]              variance,
	input  logic signed [15:0]       beta,
	input  logic signed [15:0]       gamma,
	input  logic signed [15:0]       sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [15:0]       result,
	output logic                     saturated,
	input  logic                     cfg_we,
	input  logic [15:0]              cfg_wdata
);

	logic [15:0] eps_q;
	logic        busy;
	logic        adv;
	logic        in_acc;
	logic        rd_en;
	bni_pkg::tab_wr_t wr;

	logic [bni_pkg::TAB_W-1:0] scale_rd, offset_rd;

	logic               valid_s1, ok_s1;
	logic signed [15:0] sample_s1;
	logic               valid_s2, ok_s2;
	logic signed [47:0] prod_s2;
	logic signed [31:0] off_s2;
	logic               out_valid_q;
	logic signed [15:0] result_q;
	logic               sat_q;

	logic signed [47:0] acc;
	logic signed [31:0] res;

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = busy || !adv;
	assign in_acc   = in_valid && !in_stall;
	assign rd_en    = in_acc && (command == bni_pkg::CMD_PROCESS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= bni_pkg::EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	bni_param u_param (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc && (command == bni_pkg::CMD_LOAD)),
		.channel  (channel),
		.mean     (mean),
		.variance (variance),
		.beta     (beta),
		.gamma    (gamma),
		.epsilon  (eps_q),
		.busy     (busy),
		.wr       (wr)
	);

	bni_ram #(.WIDTH(bni_pkg::TAB_W), .DEPTH(bni_pkg::CHANNELS)) u_scale_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.scale),
		.re    (rd_en),
		.raddr (bni_pkg::ADDR_W'(channel)),
		.rdata (scale_rd)
	);

	bni_ram #(.WIDTH(bni_pkg::TAB_W), .DEPTH(bni_pkg::CHANNELS)) u_offset_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.offset),
		.re    (rd_en),
		.raddr (bni_pkg::ADDR_W'(channel)),
		.rdata (offset_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= rd_en;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign acc = prod_s2 + 48'($signed({off_s2, 12'd0})) + 48'sd32768;
	assign res = 32'(acc >>> 16);

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1     <= (13'(channel) < 13'(bni_pkg::CHANNELS));
			sample_s1 <= sample;
			ok_s2     <= ok_s1;
			prod_s2   <= 48'($signed(scale_rd) * sample_s1);
			off_s2    <= $signed(offset_rd);
			if (!ok_s2) begin
				result_q <= '0;
				sat_q    <= 1'b0;
			end else if (res > 32'sd32767) begin
				result_q <= 16'sd32767;
				sat_q    <= 1'b1;
			end else if (res < -32'sd32768) begin
				result_q <= -16'sd32768;
				sat_q    <= 1'b1;
			end else begin
				result_q <= 16'(res);
				sat_q    <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign saturated = sat_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.we && rd_en))
		else $error("table write and read in the same cycle");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && command == bni_pkg::CMD_LOAD) |=> busy)
		else $error("load request did not start sequencer");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (result == 16'sd32767 || result == -16'sd32768))
		else $error("saturated flag without clipped value");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_valid_q && out_stall) |=> valid_s2)
		else $error("pipeline lost a request under stall");

endmodule

// File: test/batch_norm_inference_chk.sv
// Checker: predicts per-channel normalization results and compares the output stream.
module batch_norm_inference_chk (
	input  logic               clk,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               command,
	input  logic [5:0]         channel,
	input  logic signed [15:0] mean,
	input  logic [15:0]        variance,
	input  logic signed [15:0] beta,
	input  logic signed [15:0] gamma,
	input  logic signed [15:0] sample,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] result,
	input  logic               saturated,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic signed [15:0] value;
		logic               sat;
	} norm_t;

	logic signed [31:0] scale_mem [bni_pkg::CHANNELS];
	logic signed [31:0] offset_mem [bni_pkg::CHANNELS];
	logic [15:0] eps_q;
	norm_t expected_q [$];

	function automatic longint rshift_round(longint x, int n);
		longint d;
		longint y;
		d = longint'(1) << n;
		y = x + (d >>> 1);
		if (y >= 0) begin
			return y / d;
		end
		return -((-y + d - 1) / d);
	endfunction

	function automatic longint int_sqrt(longint v);
		longint r;
		longint b;
		r = 0;
		b = longint'(1) << 60;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	task automatic load_channel();
		longint v;
		longint r;
		longint mag;
		longint q;
		longint sc;
		v = longint'(variance) + longint'(eps_q);
		r = int_sqrt(v << 20);
		sc = 0;
		if (r != 0) begin
			mag = (gamma < 0 ? -longint'(gamma) : longint'(gamma)) << 20;
			q = (mag + (r >>> 1)) / r;
			sc = gamma < 0 ? -q : q;
		end
		scale_mem[channel] = 32'(sc);
		offset_mem[channel] = 32'(longint'(beta) * 16 - rshift_round(sc * longint'(mean), 12));
	endtask

	function automatic norm_t normalize();
		norm_t n;
		longint acc;
		longint r;
		acc = longint'(scale_mem[channel]) * longint'(sample)
			+ longint'(offset_mem[channel]) * 4096;
		r = rshift_round(acc, 16);
		n.sat = 1'b0;
		if (r > 32767) begin
			r = 32767;
			n.sat = 1'b1;
		end
		if (r < -32768) begin
			r = -32768;
			n.sat = 1'b1;
		end
		n.value = 16'(r);
		return n;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		eps_q = bni_pkg::EPS_RESET;
	end

	always @(posedge clk) begin
		norm_t e;
		if (cfg_we) begin
			eps_q = cfg_wdata;
		end
		if (in_valid && !in_stall) begin
			if (bni_pkg::cmd_t'(command) == bni_pkg::CMD_LOAD) begin
				load_channel();
			end else begin
				expected_q.push_back(normalize());
			end
		end
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %0d sat %0b", $time, result, saturated);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (e.value !== result || e.sat !== saturated) begin
					$display("%0t: expected %0d sat %0b, actual %0d sat %0b",
						$time, e.value, e.sat, result, saturated);
					errors++;
				end
			end
		end
		pending = expected_q.size();
	end
endmodule

// File: test/batch_norm_inference_top_tb.sv
// Testbench top: drives load and process requests and epsilon settings, gives the verdict.
module batch_norm_inference_top_tb;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic command;
	logic [5:0] channel;
	logic signed [15:0] mean, beta, gamma, sample;
	logic [15:0] variance;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] result;
	logic saturated;
	logic cfg_we;
	logic [15:0] cfg_wdata;
	int errors;
	int pending;
	bit loaded [bni_pkg::CHANNELS];
	int burst_left;

	batch_norm_inference_top u_dut (.*);

	batch_norm_inference_chk u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

	// receiver stall pattern
	initial begin
		int mode;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(20, 80)) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 5) != 0);
				endcase
			end
		end
	end

	task automatic send(logic cmd, logic [5:0] ch, logic [15:0] m, logic [15:0] v,
			logic [15:0] b, logic [15:0] g, logic [15:0] s);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= cmd;
		channel <= ch;
		mean <= m;
		variance <= v;
		beta <= b;
		gamma <= g;
		sample <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (cmd == bni_pkg::CMD_LOAD) begin
			loaded[ch] = 1'b1;
		end
		@(negedge clk);
	endtask

	task automatic load_rand(logic [5:0] ch);
		logic [15:0] g;
		g = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8191));
		if ($urandom_range(0, 1)) g = -g;
		send(bni_pkg::CMD_LOAD, ch, 16'($urandom), $urandom_range(0, 3) == 0 ? 16'($urandom)
			: 16'($urandom_range(0, 8192)), 16'($urandom), g, 16'd0);
	endtask

	task automatic process_rand();
		logic [5:0] ch;
		ch = 6'($urandom_range(0, bni_pkg::CHANNELS - 1));
		while (!loaded[ch]) ch = 6'($urandom_range(0, bni_pkg::CHANNELS - 1));
		send(bni_pkg::CMD_PROCESS, ch, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	task automatic set_epsilon(logic [15:0] e);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= e;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [15:0] eps_set [4];
		int guard;
		eps_set = '{16'd0, 16'hFFFF, 16'd1, 16'd41};
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = bni_pkg::CMD_LOAD;
		channel = '0;
		mean = '0;
		variance = '0;
		beta = '0;
		gamma = '0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		burst_left = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset epsilon, extremes, zero denominator under epsilon 0
		send(bni_pkg::CMD_LOAD, 6'd0, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'd0);
		send(bni_pkg::CMD_LOAD, 6'd63, 16'h7FFF, 16'd0, 16'h8000, 16'h8000, 16'd0);
		send(bni_pkg::CMD_LOAD, 6'd1, 16'd4096, 16'd4096, 16'd0, 16'd4096, 16'd0);
		send(bni_pkg::CMD_PROCESS, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h7FFF);
		send(bni_pkg::CMD_PROCESS, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
		send(bni_pkg::CMD_PROCESS, 6'd63, 16'd0, 16'd0, 16'd0, 16'd0, 16'h7FFF);
		send(bni_pkg::CMD_PROCESS, 6'd63, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
		send(bni_pkg::CMD_PROCESS, 6'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
		send(bni_pkg::CMD_PROCESS, 6'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		set_epsilon(16'd0);
		send(bni_pkg::CMD_LOAD, 6'd2, 16'h7FFF, 16'd0, 16'h1234, 16'h7FFF, 16'd0);
		send(bni_pkg::CMD_PROCESS, 6'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'h5555);
		send(bni_pkg::CMD_PROCESS, 6'd63, 16'd0, 16'd0, 16'd0, 16'd0, 16'hAAAA);

		for (int p = 0; p < 4; p++) begin
			set_epsilon(eps_set[p]);
			for (int i = 0; i < 135; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					load_rand(6'($urandom_range(0, bni_pkg::CHANNELS - 1)));
				end else begin
					process_rand();
				end
			end
		end

		in_valid <= 1'b0;
		guard = 0;
		while (pending != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (20) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
